// ----- src/rsc_pkg.sv -----
// Shared types, constants and helpers for the radix string converter.
package rsc_pkg;

    localparam int INT_BITS  = 32;
    localparam int FRAC_BITS = 32;
    localparam int AW        = $clog2(INT_BITS);
    localparam int CNT_W     = $clog2(INT_BITS + 1);
    localparam int CAP_W     = 5;
    localparam int BASE_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;

    localparam logic [CAP_W-1:0]  FRAC_CAP   = 5'd30;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;

    typedef enum logic [1:0] {
        OUT_INT,
        OUT_DOT,
        OUT_FRAC
    } out_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_EMIT_INT,
        ST_DOT,
        ST_FMUL,
        ST_EMIT_FRAC
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        logic     wr_digit;
        logic     rd_digit;
        logic     fmul;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic quo_zero;
        logic cnt_zero;
        logic bit_last;
        logic frac_done;
        logic out_free;
    } dp_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        return (d < 4'd10) ? (CHAR_ZERO + dx) : (CHAR_UPPER + dx - 7'd10);
    endfunction

endpackage

// ----- src/rsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rsc_datapath.sv -----
// Datapath: serial divider, digit store, fraction multiplier, output register.
module rsc_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rsc_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic [31:0]                        integer_part,
    input  logic [31:0]                        fraction_part,
    input  logic [rsc_pkg::BASE_W-1:0]         radix,
    input  rsc_pkg::dp_cmd_t                   cmd,
    output rsc_pkg::dp_sts_t                   sts,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [rsc_pkg::CHAR_W-1:0]         m_char,
    output logic                               m_last
);
    import rsc_pkg::*;

    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     cap_eff;
    logic [INT_BITS-1:0]  quo_reg,     quo_next;
    logic [DIGIT_W-1:0]   rem_reg,     rem_next;
    logic [AW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [BASE_W-1:0]    base_reg,    base_next;
    logic [FRAC_BITS-1:0] frac_reg,    frac_next;
    logic [DIGIT_W-1:0]   fdig_reg,    fdig_next;
    logic [CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [CAP_W-1:0]     femit_reg,   femit_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    m_char_reg,  m_char_next;
    logic                 m_last_reg,  m_last_next;

    logic [DIGIT_W:0]             trial;
    logic                         trial_ge;
    logic [DIGIT_W:0]             trial_sub;
    logic [FRAC_BITS+BASE_W-1:0]  product;
    logic [CNT_W-1:0]             cnt_m1;
    logic [DIGIT_W-1:0]           ram_rd_data;
    logic                         out_free;

    assign cap_eff = (cap_reg > FRAC_CAP) ? FRAC_CAP : cap_reg;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[INT_BITS-1]};
    assign trial_ge  = (trial >= base_reg);
    assign trial_sub = trial - base_reg;

    assign product = (FRAC_BITS + BASE_W)'(frac_reg) * (FRAC_BITS + BASE_W)'(base_reg);
    assign cnt_m1  = cnt_reg - 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        base_next    = base_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        cnt_next     = cnt_reg;
        femit_next   = femit_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;

        if (cmd.load) begin
            quo_next   = INT_BITS'(integer_part);
            frac_next  = FRAC_BITS'(fraction_part);
            cnt_next   = '0;
            femit_next = '0;
            if (radix < BASE_MIN) begin
                base_next = BASE_MIN;
            end else if (radix > BASE_MAX) begin
                base_next = BASE_MAX;
            end else begin
                base_next = radix;
            end
        end
        if (cmd.div_start) begin
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        if (cmd.div_step) begin
            quo_next     = {quo_reg[INT_BITS-2:0], trial_ge};
            rem_next     = trial_ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.wr_digit) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.rd_digit) begin
            cnt_next = cnt_m1;
        end
        if (cmd.fmul) begin
            frac_next  = product[FRAC_BITS-1:0];
            fdig_next  = product[FRAC_BITS +: DIGIT_W];
            femit_next = femit_reg + 1'b1;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_last_next  = cmd.out_last;
            case (cmd.out_sel)
                OUT_INT:  m_char_next = digit_char(ram_rd_data);
                OUT_DOT:  m_char_next = CHAR_DOT;
                OUT_FRAC: m_char_next = digit_char(fdig_reg);
                default:  m_char_next = CHAR_DOT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= FRAC_CAP;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            femit_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
            femit_reg   <= femit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        frac_reg   <= frac_next;
        fdig_reg   <= fdig_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    rsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (INT_BITS)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_digit),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd_digit),
        .rd_addr (cnt_m1[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign sts.quo_zero  = (quo_reg == '0);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.bit_last  = (bit_cnt_reg == AW'(INT_BITS - 1));
    assign sts.frac_done = (frac_reg == '0) || (femit_reg >= cap_eff);
    assign sts.out_free  = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- src/rsc_ctrl.sv -----
// Controller state machine sequencing division, digit readout and fraction steps.
module rsc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rsc_pkg::dp_sts_t sts,
    output rsc_pkg::dp_cmd_t cmd
);
    import rsc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.quo_zero)     state_next = ST_DIV;
                else if (sts.cnt_zero) state_next = ST_DOT;
                else                   state_next = ST_READ;
            end
            ST_DIV: begin
                if (sts.bit_last) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_CHECK;
            end
            ST_READ: begin
                state_next = ST_EMIT_INT;
            end
            ST_EMIT_INT: begin
                if (sts.out_free) state_next = sts.cnt_zero ? ST_DOT : ST_READ;
            end
            ST_DOT: begin
                if (sts.out_free) state_next = sts.frac_done ? ST_IDLE : ST_FMUL;
            end
            ST_FMUL: begin
                state_next = ST_EMIT_FRAC;
            end
            ST_EMIT_FRAC: begin
                if (sts.out_free) state_next = sts.frac_done ? ST_IDLE : ST_FMUL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.out_sel = OUT_DOT;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd.div_start = !sts.quo_zero;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_WRITE: begin
                cmd.wr_digit = 1'b1;
            end
            ST_READ: begin
                cmd.rd_digit = 1'b1;
            end
            ST_EMIT_INT: begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OUT_INT;
            end
            ST_DOT: begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OUT_DOT;
                cmd.out_last = sts.frac_done;
            end
            ST_FMUL: begin
                cmd.fmul = 1'b1;
            end
            ST_EMIT_FRAC: begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OUT_FRAC;
                cmd.out_last = sts.frac_done;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/radix_string_converter_core.sv -----
// Top level of the radix string converter: controller, datapath and checks.
//
// Converts an unsigned number (integer part plus 0.32 fraction) to ASCII text
// in a base from 2 to 16. One input transfer on the s_axis channel carries the
// integer part, the fraction and the radix; the block answers with a run of
// character transfers on m_axis: integer digits most significant first (none
// for a zero integer part), a '.', then fraction digits until the fraction is
// zero or max_fraction_digits (cfg_wr_data, reset 30, 31 acts as 30) is hit.
// m_axis_tlast marks the final character of each conversion.
// Sequence: each integer digit costs one pass of the bit-serial divider (one
// quotient bit per cycle) plus a check state and a store write, and later a
// store readout (read, then emit); then the '.' is emitted, and each fraction
// digit takes one multiply and one load. The divider loop dominates the time.
// Reset (aresetn low, synchronous) returns to idle, drops m_axis_tvalid and
// restores the cap to 30. A stalled receiver holds the current character in the
// output register and the sequencer waits; s_axis_tready rises again as soon as
// the last character is loaded, even while it still waits to be taken.
module radix_string_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_fraction_digits
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [31:0] integer_part, [63:32] fraction_part,
                                       // [68:64] radix, [71:69] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [6:0] character, [7] zero
    output logic        m_axis_tlast   // last_char
);
    import rsc_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [CHAR_W-1:0] m_char;

    rsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .integer_part  (s_axis_tdata[31:0]),
        .fraction_part (s_axis_tdata[63:32]),
        .radix         (s_axis_tdata[68:64]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_axis_tready),
        .m_tvalid      (m_axis_tvalid),
        .m_char        (m_char),
        .m_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, m_char};

    // one conversion at a time: an accepted transfer closes the input side
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a conversion is running");

    // only digits 0-9, A-F and '.' ever leave the block
    a_legal_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
                           (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h46) ||
                           (m_axis_tdata == 8'h2E)))
        else $error("illegal character on result stream");

    // the output register is only reloaded once its transfer is done
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten before transfer");

endmodule

// ----- dv/radix_string_converter_core_tb.sv -----
// Self-checking testbench for radix_string_converter_core: directed table plus random numbers.
module radix_string_converter_core_tb;
    import rsc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 48;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_xfer_t;

    // Directed row: typed text is empty where the predictor supplies the answer.
    typedef struct {
        logic [31:0] ip;
        logic [31:0] fp;
        logic [4:0]  rx;
        logic [4:0]  cap;
        string       text;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    char_xfer_t    pending_chars [$];
    directed_row_t directed_rows [24];
    logic [4:0]    frac_cap;
    bit            pacing_on;
    bit            hold_results;
    int            failures;
    int            items_sent;
    int            chars_seen;
    int            caps_written;
    int            cycles;

    radix_string_converter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still due",
                     cycles, pending_chars.size());
            $display("radix_string_converter_core: mismatch");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [3:0] d);
        return (d < 4'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_UPPER + CHAR_W'(d) - 7'd10;
    endfunction

    // Expected character run for one number at the current fraction cap.
    task automatic convert_to_chars(input logic [31:0] ip, input logic [31:0] fp,
                                    input logic [4:0] rx);
        logic [4:0]  base;
        logic [4:0]  cap;
        logic [31:0] q;
        logic [31:0] f;
        logic [35:0] prod;
        logic [3:0]  idig [INT_BITS];
        logic [3:0]  fdig [30];
        int          ni;
        int          nf;
        base = (rx < BASE_MIN) ? BASE_MIN : (rx > BASE_MAX) ? BASE_MAX : rx;
        cap  = (frac_cap > FRAC_CAP) ? FRAC_CAP : frac_cap;
        q  = ip;
        ni = 0;
        while (q != 0) begin
            idig[ni] = 4'(q % base);
            q = q / base;
            ni++;
        end
        // carry out of fraction * base is the next digit
        f  = fp;
        nf = 0;
        while (f != 0 && nf < cap) begin
            prod     = 36'(f) * 36'(base);
            fdig[nf] = prod[35:32];
            f        = prod[31:0];
            nf++;
        end
        for (int i = ni - 1; i >= 0; i--)
            pending_chars.push_back('{ch: ascii_of(idig[i]), last: 1'b0});
        pending_chars.push_back('{ch: CHAR_DOT, last: (nf == 0)});
        for (int i = 0; i < nf; i++)
            pending_chars.push_back('{ch: ascii_of(fdig[i]), last: (i == nf - 1)});
    endtask

    // One input transfer; called and returns at a falling edge.
    task automatic offer_number(input logic [31:0] ip, input logic [31:0] fp,
                                input logic [4:0] rx, input string typed);
        if (pacing_on) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rx, fp, ip};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (typed.len() == 0) begin
            convert_to_chars(ip, fp, rx);
        end else begin
            for (int k = 0; k < typed.len(); k++)
                pending_chars.push_back('{ch: CHAR_W'(typed[k]),
                                          last: (k == typed.len() - 1)});
        end
    endtask

    // Cap writes only with the block idle: input quiet and every character taken.
    task automatic write_cap(input logic [4:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        frac_cap = value;
        caps_written++;
    endtask

    // Receiver: random backpressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end
            m_axis_tready <= !pacing_on || ($urandom_range(99) >= 32);
        end
    end

    // Result checker: every character transfer against the oldest expectation.
    always @(posedge aclk) begin
        char_xfer_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                $error("unexpected character transfer 0x%02h last=%0b",
                       m_axis_tdata[6:0], m_axis_tlast);
                failures++;
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata[6:0] !== want.ch) begin
                    $error("character: expected 0x%02h, actual 0x%02h",
                           want.ch, m_axis_tdata[6:0]);
                    failures++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_char: expected %0b, actual %0b", want.last, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    initial begin
        logic [31:0] ip;
        logic [31:0] fp;
        logic [4:0]  rx;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 5'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        frac_cap      = FRAC_CAP;
        pacing_on     = 1'b1;
        hold_results  = 1'b0;
        failures      = 0;
        items_sent    = 0;
        chars_seen    = 0;
        caps_written  = 0;
        cycles        = 0;

        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 5'd10, 5'd30, "."},
            '{32'hFFFF_FFFF, 32'h0000_0000, 5'd16, 5'd30, "FFFFFFFF."},
            '{32'hFFFF_FFFF, 32'h0000_0000, 5'd2,  5'd30, "11111111111111111111111111111111."},
            '{32'h0000_0000, 32'h8000_0000, 5'd2,  5'd30, ".1"},
            '{32'h0000_000A, 32'h8000_0000, 5'd10, 5'd30, "10.5"},
            '{32'h0000_00FF, 32'h4000_0000, 5'd16, 5'd30, "FF.4"},
            '{32'h0000_0005, 32'h0000_0000, 5'd0,  5'd30, "101."},
            '{32'h0000_0006, 32'hC000_0000, 5'd1,  5'd30, "110.11"},
            '{32'h00AB_CDEF, 32'h0000_0000, 5'd17, 5'd30, "ABCDEF."},
            '{32'h1234_5678, 32'h8000_0000, 5'd31, 5'd30, "12345678.8"},
            '{32'h0000_0000, 32'hFFFF_FFFF, 5'd16, 5'd30, ".FFFFFFFF"},
            '{32'h0000_0008, 32'h0000_0000, 5'd8,  5'd30, "10."},
            '{32'h0000_0003, 32'hC000_0000, 5'd4,  5'd30, "3.3"},
            '{32'h0000_0001, 32'h0000_0001, 5'd2,  5'd30, ""},
            '{32'h7FFF_FFFF, 32'h5555_5555, 5'd3,  5'd30, ""},
            '{32'hDEAD_BEEF, 32'h0000_0001, 5'd10, 5'd30, ""},
            '{32'h8000_0000, 32'h8000_0001, 5'd5,  5'd30, ""},
            '{32'h0001_E240, 32'hFFFF_FFFF, 5'd6,  5'd30, ""},
            '{32'hCAFE_F00D, 32'h3333_3333, 5'd7,  5'd30, ""},
            '{32'h0000_0400, 32'h1234_5678, 5'd9,  5'd30, ""},
            '{32'h7654_3210, 32'hABCD_EF01, 5'd11, 5'd30, ""},
            '{32'h0000_002A, 32'h8000_0000, 5'd10, 5'd0,  "42."},
            '{32'h0000_0007, 32'h1234_5678, 5'd16, 5'd1,  "7.1"},
            '{32'h0000_0000, 32'h0000_0001, 5'd2,  5'd31, ""}
        };

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cap != frac_cap)
                write_cap(directed_rows[r].cap);
            offer_number(directed_rows[r].ip, directed_rows[r].fp,
                         directed_rows[r].rx, directed_rows[r].text);
        end
        offer_number(32'h0BAD_F00D, 32'hFEDC_BA98, 5'd12, "");
        offer_number(32'h1357_9BDF, 32'h0F0F_0F0F, 5'd13, "");
        offer_number(32'h2468_ACE0, 32'h7777_7777, 5'd14, "");
        offer_number(32'hFFFF_0000, 32'h0000_FFFF, 5'd15, "");

        // Random phases, each at its own cap. Phase 1 opens with a long receiver
        // hold-off so the block backs up; phase 2 runs without any idling.
        for (int p = 0; p < PHASES; p++) begin
            write_cap(p == 1 ? 5'd31 : 5'($urandom_range(31)));
            pacing_on = (p != 2);
            if (p == 1)
                hold_results = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(4))
                    0: ip = $urandom;
                    1: ip = $urandom_range(1000);
                    2: ip = 32'h0;
                    3: ip = 32'hFFFF_FFFF >> $urandom_range(31);
                    default: ip = 32'h1 << $urandom_range(31);
                endcase
                case ($urandom_range(4))
                    0: fp = $urandom;
                    1: fp = 32'h0;
                    2: fp = $urandom & 32'hFFF0_0000;
                    3: fp = 32'h1 << $urandom_range(31);
                    default: fp = $urandom | 32'h1;
                endcase
                rx = ($urandom_range(99) < 85) ? 5'($urandom_range(16, 2))
                                               : 5'($urandom_range(31));
                offer_number(ip, fp, rx, "");
            end
        end
        pacing_on = 1'b1;

        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("converted %0d numbers into %0d characters over %0d cycles",
                 items_sent, chars_seen, cycles);
        $display("fraction cap written %0d times, including 0, 1 and 31", caps_written);
        if (failures == 0)
            $display("radix_string_converter_core: match");
        else
            $display("radix_string_converter_core: mismatch");
        $finish;
    end

endmodule
